### rtl/eartm_pkg.sv
// Package: widths, constants and the CORDIC arctangent table for the rotation matrix block.
package eartm_pkg;

  localparam int unsigned CordicStages = 30;
  localparam int unsigned AngW  = 31;
  localparam int unsigned ElemW = 32;
  localparam int unsigned CW    = 34;
  localparam int unsigned ZW    = 34;

  localparam logic signed [CW-1:0] One    = CW'(64'sd1073741824);
  localparam logic signed [CW-1:0] NegOne = -CW'(64'sd1073741824);
  localparam logic signed [CW-1:0] Gain   = CW'(64'sd652032874);
  localparam logic signed [ZW-1:0] HalfPi = ZW'(64'sd1686629713);
  localparam logic signed [ZW-1:0] Pi     = ZW'(64'sd3373259426);

  typedef logic signed [AngW-1:0]  ang_t;
  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [CW-1:0]    cval_t;
  typedef logic signed [ZW-1:0]    zval_t;

  // One lane of the CORDIC chain.
  typedef struct packed {
    cval_t x;
    cval_t y;
    zval_t z;
    logic  neg;
  } lane_t;

  typedef struct packed {
    lane_t yaw;
    lane_t pitch;
    lane_t roll;
  } cell_t;

  function automatic zval_t atan_lut(input logic [5:0] i);
    zval_t r;
    case (i)
      6'd0:  r = ZW'(64'sd843314857);
      6'd1:  r = ZW'(64'sd497837829);
      6'd2:  r = ZW'(64'sd263043837);
      6'd3:  r = ZW'(64'sd133525159);
      6'd4:  r = ZW'(64'sd67021687);
      6'd5:  r = ZW'(64'sd33543516);
      6'd6:  r = ZW'(64'sd16775851);
      6'd7:  r = ZW'(64'sd8388437);
      6'd8:  r = ZW'(64'sd4194283);
      6'd9:  r = ZW'(64'sd2097149);
      6'd10: r = ZW'(64'sd1048576);
      6'd11: r = ZW'(64'sd524288);
      6'd12: r = ZW'(64'sd262144);
      6'd13: r = ZW'(64'sd131072);
      6'd14: r = ZW'(64'sd65536);
      6'd15: r = ZW'(64'sd32768);
      6'd16: r = ZW'(64'sd16384);
      6'd17: r = ZW'(64'sd8192);
      6'd18: r = ZW'(64'sd4096);
      6'd19: r = ZW'(64'sd2048);
      6'd20: r = ZW'(64'sd1024);
      6'd21: r = ZW'(64'sd512);
      6'd22: r = ZW'(64'sd256);
      6'd23: r = ZW'(64'sd128);
      6'd24: r = ZW'(64'sd64);
      6'd25: r = ZW'(64'sd32);
      6'd26: r = ZW'(64'sd16);
      6'd27: r = ZW'(64'sd8);
      6'd28: r = ZW'(64'sd4);
      6'd29: r = ZW'(64'sd2);
      6'd30: r = ZW'(64'sd1);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic cval_t sat1(input logic signed [CW+1:0] v);
    cval_t r;
    if (v > (CW+2)'(64'sd1073741824)) r = One;
    else if (v < -(CW+2)'(64'sd1073741824)) r = NegOne;
    else r = v[CW-1:0];
    return r;
  endfunction

  // Rounded Q3.30 product.
  function automatic cval_t qmul(input cval_t a, input cval_t b);
    logic signed [2*CW-1:0] p;
    p = (a * b) + (2*CW)'(64'sd536870912);
    return p[CW+29:30];
  endfunction

endpackage

### rtl/eartm_if.sv
// Valid/ready channel interfaces for angle items and matrix items.
interface eartm_ang_if;
  logic valid;
  logic ready;
  eartm_pkg::ang_t yaw_angle;
  eartm_pkg::ang_t pitch_angle;
  eartm_pkg::ang_t roll_angle;
  modport source (output valid, yaw_angle, pitch_angle, roll_angle, input ready);
  modport sink   (input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface

interface eartm_mat_if;
  logic valid;
  logic ready;
  eartm_pkg::elem_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

### rtl/euler_angles_to_rotation_matrix.sv
// Top level: Euler angles (X, Y, Z order) to 3x3 rotation matrix.
// Throughput: one item per cycle unless the output stalls;
// set by the chain of CORDIC cells and product stages.
// The whole pipeline advances when the output register is empty or being taken.
// Reset clears all valid flags; data registers are not reset.
module euler_angles_to_rotation_matrix (
  input  logic        clk_i,
  input  logic        rst_ni,
  eartm_ang_if.sink   in_i,
  eartm_mat_if.source out_o
);
  localparam int unsigned N = eartm_pkg::CordicStages;

  logic en;
  logic             v [N+1];
  eartm_pkg::cell_t d [N+1];
  logic             out_v_q;
  eartm_pkg::elem_t m_w [9];
  eartm_pkg::elem_t m_q [9];
  logic             cv;

  assign en = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  function automatic eartm_pkg::lane_t fold(input eartm_pkg::ang_t a);
    eartm_pkg::lane_t l;
    eartm_pkg::zval_t z;
    z = {{(eartm_pkg::ZW-eartm_pkg::AngW-2){a[eartm_pkg::AngW-1]}}, a, 2'b00};
    l.neg = 1'b0;
    if (z > eartm_pkg::HalfPi) begin
      z = z - eartm_pkg::Pi;
      l.neg = 1'b1;
    end else if (z < -eartm_pkg::HalfPi) begin
      z = z + eartm_pkg::Pi;
      l.neg = 1'b1;
    end
    l.z = z;
    l.x = eartm_pkg::Gain;
    l.y = '0;
    return l;
  endfunction

  assign v[0] = in_i.valid && en;
  assign d[0].yaw   = fold(in_i.yaw_angle);
  assign d[0].pitch = fold(in_i.pitch_angle);
  assign d[0].roll  = fold(in_i.roll_angle);

  for (genvar g = 0; g < N; g++) begin : g_cell
    eartm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (6'(g)),
      .en_i    (en),
      .valid_i (v[g]),
      .data_i  (d[g]),
      .valid_o (v[g+1]),
      .data_o  (d[g+1])
    );
  end

  eartm_combine u_comb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v[N]),
    .data_i  (d[N]),
    .valid_o (cv),
    .m_o     (m_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= cv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q <= m_w;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.m00 = m_q[0];
  assign out_o.m01 = m_q[1];
  assign out_o.m02 = m_q[2];
  assign out_o.m10 = m_q[3];
  assign out_o.m11 = m_q[4];
  assign out_o.m12 = m_q[5];
  assign out_o.m20 = m_q[6];
  assign out_o.m21 = m_q[7];
  assign out_o.m22 = m_q[8];

`ifndef SYNTHESIS
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_v_q |-> in_i.ready) else $error("ready low with empty output");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_o.ready |=> out_v_q && $stable(out_o.m00))
    else $error("stalled output changed");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_o.m02 <= 32'sd1073741824 && out_o.m02 >= -32'sd1073741824))
    else $error("element out of range");
`endif
endmodule

### rtl/eartm_cell.sv
// One CORDIC micro-rotation cell for three angle lanes.
module eartm_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [5:0]           stage_i,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  eartm_pkg::cell_t     data_i,
  output logic                 valid_o,
  output eartm_pkg::cell_t     data_o
);
  logic valid_q;
  eartm_pkg::cell_t data_q, data_d;

  function automatic eartm_pkg::lane_t rot(input eartm_pkg::lane_t l, input logic [5:0] s);
    eartm_pkg::lane_t o;
    eartm_pkg::zval_t a;
    a = eartm_pkg::atan_lut(s);
    o.neg = l.neg;
    if (!l.z[eartm_pkg::ZW-1]) begin
      o.x = l.x - (l.y >>> s);
      o.y = l.y + (l.x >>> s);
      o.z = l.z - a;
    end else begin
      o.x = l.x + (l.y >>> s);
      o.y = l.y - (l.x >>> s);
      o.z = l.z + a;
    end
    return o;
  endfunction

  always_comb begin
    data_d.yaw   = rot(data_i.yaw, stage_i);
    data_d.pitch = rot(data_i.pitch, stage_i);
    data_d.roll  = rot(data_i.roll, stage_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

### rtl/eartm_combine.sv
// Product stages that turn the sines and cosines into the nine matrix elements.
module eartm_combine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  eartm_pkg::cell_t    data_i,
  output logic                valid_o,
  output eartm_pkg::elem_t    m_o [9]
);
  typedef eartm_pkg::cval_t cv_t;

  logic [2:0] v_q;
  cv_t sy_q, cy_q, sp_q, cp_q, sr_q, cr_q;
  cv_t ysp_q, cysp_q, cpcr_q, cpsr_q, sycp_q, cycp_q, cysr_q, cycr_q, sysr_q, sycr_q;
  cv_t sp2_q, sr2_q, cr2_q;
  eartm_pkg::elem_t m_q [9];

  function automatic cv_t fin(input eartm_pkg::cval_t v, input logic n);
    logic signed [eartm_pkg::CW+1:0] w;
    w = n ? -(eartm_pkg::CW+2)'(v) : (eartm_pkg::CW+2)'(v);
    return eartm_pkg::sat1(w);
  endfunction

  function automatic logic signed [eartm_pkg::CW+1:0] ext(input cv_t v);
    return (eartm_pkg::CW+2)'(v);
  endfunction

  function automatic eartm_pkg::elem_t el(input logic signed [eartm_pkg::CW+1:0] v);
    cv_t s;
    s = eartm_pkg::sat1(v);
    return s[eartm_pkg::ElemW-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cy_q <= fin(data_i.yaw.x, data_i.yaw.neg);
      sy_q <= fin(data_i.yaw.y, data_i.yaw.neg);
      cp_q <= fin(data_i.pitch.x, data_i.pitch.neg);
      sp_q <= fin(data_i.pitch.y, data_i.pitch.neg);
      cr_q <= fin(data_i.roll.x, data_i.roll.neg);
      sr_q <= fin(data_i.roll.y, data_i.roll.neg);
      ysp_q  <= eartm_pkg::qmul(sy_q, sp_q);
      cysp_q <= eartm_pkg::qmul(cy_q, sp_q);
      cpcr_q <= eartm_pkg::qmul(cp_q, cr_q);
      cpsr_q <= eartm_pkg::qmul(cp_q, sr_q);
      sycp_q <= eartm_pkg::qmul(sy_q, cp_q);
      cycp_q <= eartm_pkg::qmul(cy_q, cp_q);
      cysr_q <= eartm_pkg::qmul(cy_q, sr_q);
      cycr_q <= eartm_pkg::qmul(cy_q, cr_q);
      sysr_q <= eartm_pkg::qmul(sy_q, sr_q);
      sycr_q <= eartm_pkg::qmul(sy_q, cr_q);
      sp2_q <= sp_q;
      sr2_q <= sr_q;
      cr2_q <= cr_q;
      m_q[0] <= el(ext(cpcr_q));
      m_q[1] <= el(-ext(cpsr_q));
      m_q[2] <= el(ext(sp2_q));
      m_q[3] <= el(ext(eartm_pkg::qmul(ysp_q, cr2_q)) + ext(cysr_q));
      m_q[4] <= el(ext(cycr_q) - ext(eartm_pkg::qmul(ysp_q, sr2_q)));
      m_q[5] <= el(-ext(sycp_q));
      m_q[6] <= el(ext(sysr_q) - ext(eartm_pkg::qmul(cysp_q, cr2_q)));
      m_q[7] <= el(ext(eartm_pkg::qmul(cysp_q, sr2_q)) + ext(sycr_q));
      m_q[8] <= el(ext(cycp_q));
    end
  end

  assign valid_o = v_q[2];
  assign m_o = m_q;
  logic unused;
  assign unused = ^{data_i.yaw.z, data_i.pitch.z, data_i.roll.z};
endmodule

### sim/tb_euler_angles_to_rotation_matrix.sv
// Testbench: random and directed angle items checked against a CORDIC rotation-matrix predictor.
module tb_euler_angles_to_rotation_matrix;

  typedef struct {
    longint e [9];
  } matrix_t;

  logic clk_i;
  logic rst_ni;
  eartm_ang_if ang_ch ();
  eartm_mat_if mat_ch ();

  euler_angles_to_rotation_matrix dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (ang_ch.sink),
    .out_o (mat_ch.source)
  );

  localparam longint QOne = 64'sd1073741824;
  localparam longint AngMax = 64'sd843314857;
  localparam longint AtanTab [31] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16,
    8, 4, 2, 1};

  matrix_t expected_mats [$];
  int      errors;
  bit      rx_hold;
  bit      no_idle;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint clamp_one(longint v);
    if (v > QOne) return QOne;
    if (v < -QOne) return -QOne;
    return v;
  endfunction

  function automatic longint round_mul(longint a, longint b);
    return (a * b + (64'sd1 << 29)) >>> 30;
  endfunction

  task automatic cordic_sincos(input eartm_pkg::ang_t ang, output longint s,
                               output longint c);
    longint z, x, y, nx;
    bit flip;
    z = longint'(ang) * 4;
    x = 64'sd652032874;
    y = 0;
    flip = 0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      flip = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      flip = 1;
    end
    for (int i = 0; i < eartm_pkg::CordicStages && i < 40; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= (i < 31) ? AtanTab[i] : 0;
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += (i < 31) ? AtanTab[i] : 0;
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clamp_one(x);
    s = clamp_one(y);
  endtask

  task automatic predict_matrix(input eartm_pkg::ang_t yw, input eartm_pkg::ang_t pt,
                                input eartm_pkg::ang_t rl, output matrix_t m);
    longint sy, cy, sp, cp, sr, cr, ysp, cysp;
    cordic_sincos(yw, sy, cy);
    cordic_sincos(pt, sp, cp);
    cordic_sincos(rl, sr, cr);
    ysp = round_mul(sy, sp);
    cysp = round_mul(cy, sp);
    m.e[0] = clamp_one(round_mul(cp, cr));
    m.e[1] = clamp_one(-round_mul(cp, sr));
    m.e[2] = clamp_one(sp);
    m.e[3] = clamp_one(round_mul(ysp, cr) + round_mul(cy, sr));
    m.e[4] = clamp_one(round_mul(cy, cr) - round_mul(ysp, sr));
    m.e[5] = clamp_one(-round_mul(sy, cp));
    m.e[6] = clamp_one(round_mul(sy, sr) - round_mul(cysp, cr));
    m.e[7] = clamp_one(round_mul(cysp, sr) + round_mul(sy, cr));
    m.e[8] = clamp_one(round_mul(cy, cp));
  endtask

  task automatic send_angles(input eartm_pkg::ang_t yw, input eartm_pkg::ang_t pt,
                             input eartm_pkg::ang_t rl);
    matrix_t m;
    while (!no_idle && $urandom_range(99) < 38) begin
      ang_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    ang_ch.valid <= 1'b1;
    ang_ch.yaw_angle <= yw;
    ang_ch.pitch_angle <= pt;
    ang_ch.roll_angle <= rl;
    predict_matrix(yw, pt, rl, m);
    do @(posedge clk_i); while (!ang_ch.ready);
    expected_mats = {expected_mats, m};
    @(negedge clk_i);
  endtask

  function automatic eartm_pkg::ang_t rand_angle();
    case ($urandom_range(3))
      0: return eartm_pkg::ang_t'($urandom);
      1: return eartm_pkg::ang_t'($urandom_range(2 * AngMax) - AngMax);
      2: return eartm_pkg::ang_t'($urandom_range(2000) - 1000);
      default: return eartm_pkg::ang_t'($urandom_range(1) ? AngMax - $urandom_range(5000)
                                                          : -AngMax + $urandom_range(5000));
    endcase
  endfunction

  task automatic drain_matrices();
    ang_ch.valid <= 1'b0;
    while (expected_mats.size() != 0) @(negedge clk_i);
  endtask

  // Ready side with random stalls.
  initial begin
    mat_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      mat_ch.ready <= !rx_hold && (no_idle || $urandom_range(99) >= 38);
    end
  end

  always @(posedge clk_i) begin
    matrix_t m;
    eartm_pkg::elem_t got [9];
    if (rst_ni && mat_ch.valid && mat_ch.ready) begin
      got = '{mat_ch.m00, mat_ch.m01, mat_ch.m02, mat_ch.m10, mat_ch.m11,
              mat_ch.m12, mat_ch.m20, mat_ch.m21, mat_ch.m22};
      if (expected_mats.size() == 0) begin
        $display("%0t: unexpected matrix item", $time);
        errors++;
      end else begin
        m = expected_mats.pop_front();
        for (int k = 0; k < 9; k++)
          if (got[k] !== eartm_pkg::elem_t'(m.e[k])) begin
            $display("%0t: element %0d expected %0d actual %0d", $time, k,
                     eartm_pkg::elem_t'(m.e[k]), got[k]);
            errors++;
          end
      end
    end
  end

  task automatic test_directed();
    eartm_pkg::ang_t vals [7] = '{0, eartm_pkg::ang_t'(AngMax), eartm_pkg::ang_t'(-AngMax),
                                  eartm_pkg::ang_t'(32'h3FFFFFFF),
                                  eartm_pkg::ang_t'(32'h40000000),
                                  eartm_pkg::ang_t'(421657428),
                                  eartm_pkg::ang_t'(-421657429)};
    for (int i = 0; i < 7; i++) send_angles(vals[i], vals[(i + 2) % 7], vals[(i + 5) % 7]);
    send_angles(eartm_pkg::ang_t'(421657428), eartm_pkg::ang_t'(421657428),
                eartm_pkg::ang_t'(421657428));
    send_angles(eartm_pkg::ang_t'(-1), eartm_pkg::ang_t'(1), eartm_pkg::ang_t'(-1));
    drain_matrices();
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) send_angles(rand_angle(), rand_angle(), rand_angle());
  endtask

  task automatic test_backpressure();
    fork
      begin
        rx_hold = 1;
        repeat (120) @(negedge clk_i);
        rx_hold = 0;
      end
      test_random(60);
    join
    drain_matrices();
  endtask

  task automatic test_no_idle();
    no_idle = 1;
    test_random(100);
    no_idle = 0;
  endtask

  initial begin
    errors = 0;
    rx_hold = 0;
    no_idle = 0;
    rst_ni = 1'b0;
    ang_ch.valid = 1'b0;
    ang_ch.yaw_angle = '0;
    ang_ch.pitch_angle = '0;
    ang_ch.roll_angle = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(220);
    drain_matrices();
    test_backpressure();
    test_no_idle();
    test_random(220);
    drain_matrices();
    repeat (eartm_pkg::CordicStages + 20) @(negedge clk_i);
    if (errors == 0 && expected_mats.size() == 0)
      $display("tb_euler_angles_to_rotation_matrix passed");
    else
      $display("tb_euler_angles_to_rotation_matrix failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_euler_angles_to_rotation_matrix failed");
    $finish;
  end
endmodule
